// ===== hdl/char_lcd_cursor_writer_macros.svh =====
// Assertion macros for the checks in the top-level file of this block.
`ifndef CHAR_LCD_CURSOR_WRITER_MACROS_SVH
`define CHAR_LCD_CURSOR_WRITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLCW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/clcw_pkg.sv =====
`timescale 1ns / 1ps

package clcw_pkg;

  localparam int unsigned UpcW = 5;

  localparam logic [7:0] SecondLineAddr = 8'd64;
  localparam logic [7:0] DropLimit      = 8'h80;
  localparam logic [7:0] SetAddrCmd     = 8'h80;
  localparam logic [7:0] ClearCmd       = 8'h01;
  localparam logic [7:0] NewlineCode    = 8'h0A;
  localparam logic [7:0] SpaceCode      = 8'h20;
  localparam logic [7:0] DigitZero      = 8'd48;
  localparam logic [5:0] MaxWidth       = 6'd40;
  localparam logic [5:0] ResetWidth     = 6'd16;
  localparam logic [2:0] LastPos        = 3'd4;

  typedef enum logic [2:0] {
    OP_PUTC   = 3'd0,
    OP_TOGGLE = 3'd1,
    OP_LSTART = 3'd2,
    OP_BLANK  = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_NUMBER = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    J_DISPATCH,
    J_NEXT,
    J_GOTO,
    J_BRANCH
  } jump_e;

  typedef enum logic [2:0] {
    T_DROP,
    T_NEWLINE,
    T_SPACES_DONE,
    T_LT_DIV,
    T_LAST_POS,
    T_SKIP
  } test_e;

  typedef enum logic [2:0] {
    SRC_SETADDR,
    SRC_CLEAR,
    SRC_CHAR,
    SRC_SPACE,
    SRC_DIGIT
  } src_e;

  typedef enum logic [1:0] {
    A_SECOND,
    A_ZERO,
    A_TOGGLE,
    A_BASE
  } addr_e;

  typedef enum logic [1:0] {
    DP_NONE,
    DP_DEC_CNT,
    DP_SUB_DIV,
    DP_NEXT_POS
  } dp_e;

  typedef struct packed {
    logic            emit;
    src_e            src;
    addr_e           addr;
    logic            long_wait;
    logic            last;
    dp_e             dp;
    test_e           test;
    jump_e           jump;
    logic [UpcW-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic   go;
    logic   load;
    ucode_t uw;
  } ctrl_t;

  typedef struct packed {
    logic slot_free;
    logic drop;
    logic newline;
    logic spaces_done;
    logic lt_div;
    logic last_pos;
    logic skip;
  } status_t;

  localparam logic [UpcW-1:0] UPC_IDLE        = 5'd0;
  localparam logic [UpcW-1:0] UPC_PUTC        = 5'd1;
  localparam logic [UpcW-1:0] UPC_PUTC_NL     = 5'd2;
  localparam logic [UpcW-1:0] UPC_PUTC_DATA   = 5'd3;
  localparam logic [UpcW-1:0] UPC_PUTC_SECOND = 5'd4;
  localparam logic [UpcW-1:0] UPC_TOGGLE      = 5'd5;
  localparam logic [UpcW-1:0] UPC_LSTART      = 5'd6;
  localparam logic [UpcW-1:0] UPC_BLANK       = 5'd7;
  localparam logic [UpcW-1:0] UPC_BLANK_TEST  = 5'd8;
  localparam logic [UpcW-1:0] UPC_BLANK_SPACE = 5'd9;
  localparam logic [UpcW-1:0] UPC_BLANK_END   = 5'd10;
  localparam logic [UpcW-1:0] UPC_CLEAR       = 5'd11;
  localparam logic [UpcW-1:0] UPC_CLEAR_HOME  = 5'd12;
  localparam logic [UpcW-1:0] UPC_NUM         = 5'd13;
  localparam logic [UpcW-1:0] UPC_NUM_SUB     = 5'd14;
  localparam logic [UpcW-1:0] UPC_NUM_POS     = 5'd15;
  localparam logic [UpcW-1:0] UPC_NUM_SKIPT   = 5'd16;
  localparam logic [UpcW-1:0] UPC_NUM_DIGIT   = 5'd17;
  localparam logic [UpcW-1:0] UPC_NUM_SKIP    = 5'd18;
  localparam logic [UpcW-1:0] UPC_NUM_LAST    = 5'd19;

  localparam ucode_t UcodeIdle = '{
    emit: 1'b0, src: SRC_SETADDR, addr: A_ZERO, long_wait: 1'b0, last: 1'b0,
    dp: DP_NONE, test: T_DROP, jump: J_GOTO, target: UPC_IDLE
  };

  function automatic ucode_t clcw_ucode(input logic [UpcW-1:0] upc);
    ucode_t w;
    w = UcodeIdle;
    unique case (upc)
      UPC_IDLE: begin
        w.jump = J_DISPATCH;
      end
      UPC_PUTC: begin
        w.test = T_DROP;
        w.jump = J_BRANCH;
        w.target = UPC_IDLE;
      end
      UPC_PUTC_NL: begin
        w.test = T_NEWLINE;
        w.jump = J_BRANCH;
        w.target = UPC_PUTC_SECOND;
      end
      UPC_PUTC_DATA: begin
        w.emit = 1'b1;
        w.src = SRC_CHAR;
        w.last = 1'b1;
      end
      UPC_PUTC_SECOND: begin
        w.emit = 1'b1;
        w.addr = A_SECOND;
        w.last = 1'b1;
      end
      UPC_TOGGLE: begin
        w.emit = 1'b1;
        w.addr = A_TOGGLE;
        w.last = 1'b1;
      end
      UPC_LSTART: begin
        w.emit = 1'b1;
        w.addr = A_BASE;
        w.last = 1'b1;
      end
      UPC_BLANK: begin
        w.emit = 1'b1;
        w.addr = A_BASE;
        w.jump = J_NEXT;
      end
      UPC_BLANK_TEST: begin
        w.test = T_SPACES_DONE;
        w.jump = J_BRANCH;
        w.target = UPC_BLANK_END;
      end
      UPC_BLANK_SPACE: begin
        w.emit = 1'b1;
        w.src = SRC_SPACE;
        w.dp = DP_DEC_CNT;
        w.target = UPC_BLANK_TEST;
      end
      UPC_BLANK_END: begin
        w.emit = 1'b1;
        w.addr = A_BASE;
        w.last = 1'b1;
      end
      UPC_CLEAR: begin
        w.emit = 1'b1;
        w.src = SRC_CLEAR;
        w.long_wait = 1'b1;
        w.jump = J_NEXT;
      end
      UPC_CLEAR_HOME: begin
        w.emit = 1'b1;
        w.addr = A_ZERO;
        w.last = 1'b1;
      end
      UPC_NUM: begin
        w.test = T_LT_DIV;
        w.jump = J_BRANCH;
        w.target = UPC_NUM_POS;
      end
      UPC_NUM_SUB: begin
        w.dp = DP_SUB_DIV;
        w.target = UPC_NUM;
      end
      UPC_NUM_POS: begin
        w.test = T_LAST_POS;
        w.jump = J_BRANCH;
        w.target = UPC_NUM_LAST;
      end
      UPC_NUM_SKIPT: begin
        w.test = T_SKIP;
        w.jump = J_BRANCH;
        w.target = UPC_NUM_SKIP;
      end
      UPC_NUM_DIGIT: begin
        w.emit = 1'b1;
        w.src = SRC_DIGIT;
        w.dp = DP_NEXT_POS;
        w.target = UPC_NUM;
      end
      UPC_NUM_SKIP: begin
        w.dp = DP_NEXT_POS;
        w.target = UPC_NUM;
      end
      UPC_NUM_LAST: begin
        w.emit = 1'b1;
        w.src = SRC_DIGIT;
        w.last = 1'b1;
      end
      default: begin
        w = UcodeIdle;
      end
    endcase
    return w;
  endfunction

  function automatic logic [UpcW-1:0] clcw_dispatch(input logic [2:0] op);
    logic [UpcW-1:0] upc;
    unique case (op)
      OP_PUTC:   upc = UPC_PUTC;
      OP_TOGGLE: upc = UPC_TOGGLE;
      OP_LSTART: upc = UPC_LSTART;
      OP_BLANK:  upc = UPC_BLANK;
      OP_CLEAR:  upc = UPC_CLEAR;
      OP_NUMBER: upc = UPC_NUM;
      default:   upc = UPC_IDLE;
    endcase
    return upc;
  endfunction

  function automatic logic [13:0] clcw_divisor(input logic [2:0] pos);
    logic [13:0] d;
    unique case (pos)
      3'd0:    d = 14'd10000;
      3'd1:    d = 14'd1000;
      3'd2:    d = 14'd100;
      3'd3:    d = 14'd10;
      default: d = 14'd1;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/clcw_sequencer.sv =====
`timescale 1ns / 1ps

module clcw_sequencer import clcw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] opcode_i,
  input  status_t    status_i,
  output logic       in_ready_o,
  output ctrl_t      ctrl_o
);

  logic [UpcW-1:0] upc_q, upc_d;
  ucode_t          uw;
  logic            test;
  logic            stall;
  logic            accept;

  assign uw         = clcw_ucode(upc_q);
  assign in_ready_o = (upc_q == UPC_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign stall      = uw.emit && !status_i.slot_free;

  always_comb begin
    unique case (uw.test)
      T_DROP:        test = status_i.drop;
      T_NEWLINE:     test = status_i.newline;
      T_SPACES_DONE: test = status_i.spaces_done;
      T_LT_DIV:      test = status_i.lt_div;
      T_LAST_POS:    test = status_i.last_pos;
      T_SKIP:        test = status_i.skip;
      default:       test = 1'b0;
    endcase
  end

  always_comb begin
    upc_d = upc_q;
    if (!stall) begin
      unique case (uw.jump)
        J_DISPATCH: upc_d = accept ? clcw_dispatch(opcode_i) : upc_q;
        J_NEXT:     upc_d = upc_q + 5'd1;
        J_GOTO:     upc_d = uw.target;
        J_BRANCH:   upc_d = test ? uw.target : upc_q + 5'd1;
        default:    upc_d = UPC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o.go   = !stall;
  assign ctrl_o.load = accept;
  assign ctrl_o.uw   = uw;

endmodule

// ===== hdl/clcw_datapath.sv =====
`timescale 1ns / 1ps

module clcw_datapath import clcw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  input  logic [7:0]  char_code_i,
  input  logic [15:0] number_value_i,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        out_ready_i,
  output status_t     status_o,
  output logic        out_valid_o,
  output logic        is_data_o,
  output logic [7:0]  bus_byte_o,
  output logic        long_wait_o,
  output logic        last_write_o
);

  logic [5:0]  line_width_q;
  logic [7:0]  cursor_q, cursor_d;
  logic [7:0]  char_q;
  logic [15:0] num_q;
  logic [5:0]  cnt_q;
  logic [2:0]  pos_q;
  logic [3:0]  digit_q;
  logic        started_q;
  logic        out_valid_q;
  logic        is_data_q, long_wait_q, last_q;
  logic [7:0]  byte_q;

  logic [13:0] divisor;
  logic        on_second;
  logic [7:0]  new_addr;
  logic [7:0]  emit_byte;
  logic        emit_data;
  logic        fire;

  assign divisor   = clcw_divisor(pos_q);
  assign on_second = (cursor_q >= SecondLineAddr);
  assign fire      = ctrl_i.go && ctrl_i.uw.emit;

  always_comb begin
    unique case (ctrl_i.uw.addr)
      A_SECOND: new_addr = SecondLineAddr;
      A_ZERO:   new_addr = 8'd0;
      A_TOGGLE: new_addr = on_second ? 8'd0 : SecondLineAddr;
      A_BASE:   new_addr = on_second ? SecondLineAddr : 8'd0;
      default:  new_addr = 8'd0;
    endcase
  end

  always_comb begin
    emit_data = 1'b1;
    cursor_d  = cursor_q + 8'd1;
    unique case (ctrl_i.uw.src)
      SRC_SETADDR: begin
        emit_byte = SetAddrCmd | new_addr;
        emit_data = 1'b0;
        cursor_d  = new_addr;
      end
      SRC_CLEAR: begin
        emit_byte = ClearCmd;
        emit_data = 1'b0;
        cursor_d  = cursor_q;
      end
      SRC_CHAR:  emit_byte = char_q;
      SRC_SPACE: emit_byte = SpaceCode;
      SRC_DIGIT: emit_byte = DigitZero + {4'd0, digit_q};
      default: begin
        emit_byte = 8'd0;
        emit_data = 1'b0;
        cursor_d  = cursor_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= ResetWidth;
      cursor_q     <= 8'd0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        line_width_q <= (cfg_wdata_i > MaxWidth) ? MaxWidth : cfg_wdata_i;
      end
      if (fire) begin
        cursor_q    <= cursor_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      is_data_q   <= emit_data;
      byte_q      <= emit_byte;
      long_wait_q <= ctrl_i.uw.long_wait;
      last_q      <= ctrl_i.uw.last;
    end
    if (ctrl_i.load) begin
      char_q    <= char_code_i;
      num_q     <= number_value_i;
      cnt_q     <= line_width_q;
      pos_q     <= 3'd0;
      digit_q   <= 4'd0;
      started_q <= 1'b0;
    end else if (ctrl_i.go) begin
      unique case (ctrl_i.uw.dp)
        DP_NONE: begin
        end
        DP_DEC_CNT: begin
          cnt_q <= cnt_q - 6'd1;
        end
        DP_SUB_DIV: begin
          num_q   <= num_q - {2'b00, divisor};
          digit_q <= digit_q + 4'd1;
        end
        DP_NEXT_POS: begin
          started_q <= started_q || (digit_q != 4'd0);
          digit_q   <= 4'd0;
          pos_q     <= pos_q + 3'd1;
        end
        default: begin
        end
      endcase
    end
  end

  assign status_o.slot_free   = !out_valid_q || out_ready_i;
  assign status_o.drop        = (cursor_q > DropLimit);
  assign status_o.newline     = (char_q == NewlineCode);
  assign status_o.spaces_done = (cnt_q == 6'd0) || (cursor_q > DropLimit);
  assign status_o.lt_div      = (num_q < {2'b00, divisor});
  assign status_o.last_pos    = (pos_q == LastPos);
  assign status_o.skip        = (digit_q == 4'd0) && !started_q;

  assign out_valid_o  = out_valid_q;
  assign is_data_o    = is_data_q;
  assign bus_byte_o   = byte_q;
  assign long_wait_o  = long_wait_q;
  assign last_write_o = last_q;

endmodule

// ===== hdl/char_lcd_cursor_writer.sv =====
// A beat appears in the cycle after the microcode step that makes it.
// One item at a time; how long each item takes is set by the microcode step counter and the
// repeated-subtraction digit loop, plus output stalls.
// Reset: rst_ni clears the step counter, the cursor address, the output valid and sets
// the line width to 16.
`timescale 1ns / 1ps
`include "char_lcd_cursor_writer_macros.svh"

module char_lcd_cursor_writer import clcw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  char_code_i,
  input  logic [15:0] number_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_data_o,
  output logic [7:0]  bus_byte_o,
  output logic        long_wait_o,
  output logic        last_write_o,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i
);

  ctrl_t   ctrl;
  status_t status;

  clcw_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  clcw_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .char_code_i    (char_code_i),
    .number_value_i (number_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_ready_i    (out_ready_i),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .is_data_o      (is_data_o),
    .bus_byte_o     (bus_byte_o),
    .long_wait_o    (long_wait_o),
    .last_write_o   (last_write_o)
  );

  `CLCW_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o && clcw_dispatch(opcode_i) != UPC_IDLE, !in_ready_o, "Block stayed ready after accepting a valid opcode.")
  `CLCW_ASSERT_IMPL(a_long_wait_clear, clk_i, rst_ni, out_valid_o && long_wait_o, !is_data_o && bus_byte_o == ClearCmd, "Long wait on a beat that is not the clear command.")
  `CLCW_ASSERT_IMPL(a_cmd_form, clk_i, rst_ni, out_valid_o && !is_data_o && !long_wait_o, bus_byte_o[7], "Command beat is not a set-address command.")

endmodule

// ===== bench/char_lcd_cursor_writer_test.sv =====
`timescale 1ns / 1ps

module char_lcd_cursor_writer_test;
  import clcw_pkg::*;

  localparam logic [2:0] OpSpareA = 3'd6;
  localparam logic [2:0] OpSpareB = 3'd7;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned LongHold = 400;
  localparam int unsigned RunHead = 12;
  localparam int unsigned RunTail = 26;
  localparam int unsigned PhaseItems = 7;

  typedef enum int unsigned {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_EVERY_THIRD,
    RDY_MOSTLY,
    RDY_HOLD
  } ready_mode_e;

  class lcd_write_tracker;
    typedef struct packed {
      logic       is_data;
      logic [7:0] bus_byte;
      logic       long_wait;
      logic       last_write;
    } lcd_write_t;

    logic [5:0] width;
    logic [7:0] cursor;
    lcd_write_t pending_writes[$];
    lcd_write_t item_writes[$];
    int unsigned fail_count;

    function new();
      width = ResetWidth;
      cursor = '0;
      fail_count = 0;
    endfunction

    function void set_width(logic [5:0] v);
      width = (v > MaxWidth) ? MaxWidth : v;
    endfunction

    function logic [7:0] line_start();
      return (cursor >= SecondLineAddr) ? SecondLineAddr : 8'h00;
    endfunction

    function void add_write(logic d, logic [7:0] b, logic lw);
      lcd_write_t w;
      w.is_data = d;
      w.bus_byte = b;
      w.long_wait = lw;
      w.last_write = 1'b0;
      item_writes.push_back(w);
    endfunction

    function void go_to(logic [7:0] a);
      cursor = a;
      add_write(1'b0, SetAddrCmd | a, 1'b0);
    endfunction

    function void write_char(logic [7:0] b);
      add_write(1'b1, b, 1'b0);
      cursor = cursor + 8'd1;
    endfunction

    // Works out the LCD writes that one accepted event causes.
    function void note_event(logic [2:0] op, logic [7:0] ch, logic [15:0] num);
      int unsigned divisor;
      int unsigned rest;
      int unsigned digit;
      int unsigned n;
      bit started;
      item_writes.delete();
      case (op)
        OP_PUTC: begin
          if (cursor <= DropLimit) begin
            if (ch == NewlineCode) go_to(SecondLineAddr);
            else write_char(ch);
          end
        end
        OP_TOGGLE: begin
          go_to((cursor >= SecondLineAddr) ? 8'h00 : SecondLineAddr);
        end
        OP_LSTART: begin
          go_to(line_start());
        end
        OP_BLANK: begin
          go_to(line_start());
          n = 0;
          while (n < width && cursor <= DropLimit) begin
            write_char(SpaceCode);
            n++;
          end
          go_to(line_start());
        end
        OP_CLEAR: begin
          add_write(1'b0, ClearCmd, 1'b1);
          go_to(8'h00);
        end
        OP_NUMBER: begin
          if (num == 16'd0) begin
            write_char(DigitZero);
          end else begin
            rest = num;
            started = 1'b0;
            divisor = 10000;
            while (divisor != 0) begin
              digit = rest / divisor;
              if (digit != 0 || started) begin
                write_char(DigitZero + digit[7:0]);
                started = 1'b1;
              end
              rest = rest % divisor;
              divisor = divisor / 10;
            end
          end
        end
        default: begin
        end
      endcase
      if (item_writes.size() != 0) item_writes[item_writes.size() - 1].last_write = 1'b1;
      foreach (item_writes[i]) pending_writes.push_back(item_writes[i]);
    endfunction

    function void check_write(logic d, logic [7:0] b, logic lw, logic last);
      lcd_write_t w;
      if (pending_writes.size() == 0) begin
        $error("unexpected write beat: is_data %0d bus_byte %02h", d, b);
        fail_count++;
        return;
      end
      w = pending_writes.pop_front();
      if (d !== w.is_data) begin
        $error("is_data: expected %0d, got %0d", w.is_data, d);
        fail_count++;
      end
      if (b !== w.bus_byte) begin
        $error("bus_byte: expected %02h, got %02h", w.bus_byte, b);
        fail_count++;
      end
      if (lw !== w.long_wait) begin
        $error("long_wait: expected %0d, got %0d", w.long_wait, lw);
        fail_count++;
      end
      if (last !== w.last_write) begin
        $error("last_write: expected %0d, got %0d", w.last_write, last);
        fail_count++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_writes.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  opcode_i;
  logic [7:0]  char_code_i;
  logic [15:0] number_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        is_data_o;
  logic [7:0]  bus_byte_o;
  logic        long_wait_o;
  logic        last_write_o;
  logic        cfg_we_i;
  logic [5:0]  cfg_wdata_i;

  lcd_write_tracker board;
  int unsigned burst_left;
  int unsigned quiet_cycles;

  char_lcd_cursor_writer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .char_code_i    (char_code_i),
    .number_value_i (number_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .is_data_o      (is_data_o),
    .bus_byte_o     (bus_byte_o),
    .long_wait_o    (long_wait_o),
    .last_write_o   (last_write_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        board.check_write(is_data_o, bus_byte_o, long_wait_o, last_write_o);
      end
      if (in_valid_i && in_ready_o) begin
        board.note_event(opcode_i, char_code_i, number_value_i);
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles == WatchdogLimit) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned episode;
    int unsigned span;
    ready_mode_e mode;
    out_ready_i = 1'b0;
    episode = 0;
    forever begin
      mode = (episode == 4) ? RDY_HOLD : ready_mode_e'($urandom_range(0, 3));
      span = (mode == RDY_HOLD) ? LongHold : $urandom_range(8, 60);
      for (int unsigned k = 0; k < span; k++) begin
        @(negedge clk_i);
        case (mode)
          RDY_ALWAYS:      out_ready_i = 1'b1;
          RDY_COIN:        out_ready_i = $urandom_range(0, 1);
          RDY_EVERY_THIRD: out_ready_i = (k % 3 == 0);
          RDY_MOSTLY:      out_ready_i = ($urandom_range(0, 4) != 0);
          default:         out_ready_i = 1'b0;
        endcase
      end
      episode++;
    end
  end

  task automatic offer(input logic [2:0] op, input logic [7:0] ch, input logic [15:0] num);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        opcode_i = 3'($urandom);
        char_code_i = 8'($urandom);
        number_value_i = 16'($urandom);
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    opcode_i = op;
    char_code_i = ch;
    number_value_i = num;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [5:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    board.set_width(v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_event();
    int unsigned r;
    int unsigned mag;
    int unsigned top;
    logic [2:0] op;
    logic [7:0] ch;
    logic [15:0] num;
    r = $urandom_range(0, 99);
    if (r < 30) op = OP_PUTC;
    else if (r < 57) op = OP_NUMBER;
    else if (r < 66) op = OP_TOGGLE;
    else if (r < 74) op = OP_LSTART;
    else if (r < 86) op = OP_BLANK;
    else if (r < 93) op = OP_CLEAR;
    else if (r < 97) op = OpSpareA;
    else op = OpSpareB;
    ch = ($urandom_range(0, 6) == 0) ? NewlineCode : 8'($urandom_range(0, 255));
    mag = $urandom_range(0, 5);
    top = 1;
    repeat (mag) top = top * 10;
    num = (mag == 5) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, top - 1));
    offer(op, ch, num);
  endtask

  // Walks the cursor onto the second line, past the drop threshold and around the wrap.
  task automatic cursor_run();
    logic [7:0] ch;
    offer(OP_CLEAR, 8'($urandom), 16'($urandom));
    offer(OP_TOGGLE, 8'($urandom), 16'($urandom));
    repeat (RunHead) offer(OP_NUMBER, 8'($urandom), 16'($urandom_range(10000, 65535)));
    offer(OP_NUMBER, 8'($urandom), 16'($urandom_range(1000, 9999)));
    ch = 8'($urandom);
    if (ch == NewlineCode) ch = 8'h41;
    offer(OP_PUTC, ch, 16'($urandom));
    offer(OP_PUTC, 8'($urandom), 16'($urandom));
    offer(OP_PUTC, NewlineCode, 16'($urandom));
    repeat (RunTail) offer(OP_NUMBER, 8'($urandom), 16'($urandom_range(10000, 65535)));
    offer(OP_PUTC, 8'($urandom), 16'($urandom));
    offer(OP_TOGGLE, 8'($urandom), 16'($urandom));
  endtask

  initial begin
    logic [5:0] widths[6];
    board = new();
    burst_left = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = OP_PUTC;
    char_code_i = 8'h00;
    number_value_i = 16'h0000;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 6'd0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    offer(OP_PUTC, 8'h41, 16'h0000);
    offer(OP_PUTC, NewlineCode, 16'hffff);
    offer(OP_PUTC, 8'hff, 16'h0000);
    offer(OP_PUTC, 8'h00, 16'h0000);
    offer(OP_PUTC, NewlineCode, 16'h0000);
    offer(OP_TOGGLE, 8'h00, 16'h0000);
    offer(OP_TOGGLE, 8'hff, 16'hffff);
    offer(OP_BLANK, 8'h00, 16'h0000);
    offer(OP_LSTART, 8'h00, 16'h0000);
    offer(OP_TOGGLE, 8'h00, 16'h0000);
    offer(OP_LSTART, 8'h00, 16'h0000);
    offer(OP_BLANK, 8'h00, 16'h0000);
    offer(OP_CLEAR, 8'h00, 16'h0000);
    offer(OP_NUMBER, 8'h00, 16'd0);
    offer(OP_NUMBER, 8'h00, 16'd65535);
    offer(OP_NUMBER, 8'h00, 16'd10000);
    offer(OP_NUMBER, 8'h00, 16'd9);
    offer(OP_NUMBER, 8'h00, 16'd100);
    offer(OP_NUMBER, 8'hff, 16'd1);
    offer(OpSpareA, 8'hff, 16'hffff);
    offer(OpSpareB, 8'h0a, 16'h0000);
    offer(OP_PUTC, 8'h7f, 16'h0000);
    drain();

    widths = '{6'd40, 6'd0, 6'd63, 6'd1, 6'd41, 6'($urandom_range(2, 39))};
    foreach (widths[p]) begin
      write_width(widths[p]);
      if (p == 0) cursor_run();
      for (int unsigned k = 0; k < ((p == 0) ? 10 : PhaseItems); k++) random_event();
      drain();
    end

    if (board.fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
